// ===== rtl/assert_macros.svh =====
// assertion macros for the rtl files
// no dependencies; included by modules that carry concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check under synchronous active-low reset
`define ASSERT_SYNC(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("assertion failed");

// check at every clock edge, reset included
`define ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("assertion failed");

`endif

// ===== rtl/calaw_pkg.sv =====
// types, register indexes and widths for the calendar alarm window match
// no dependencies; used by every module of the block
`default_nettype none

package calaw_pkg;

    localparam int unsigned IDX_W = 3;
    localparam int unsigned CFG_DATA_W = 13;
    localparam int unsigned S_DATA_W = 48;
    localparam int unsigned M_DATA_W = 8;

    localparam logic [IDX_W-1:0] REG_YEAR = 3'd0;
    localparam logic [IDX_W-1:0] REG_MONTH_MASK = 3'd1;
    localparam logic [IDX_W-1:0] REG_WEEKDAY_MASK = 3'd2;
    localparam logic [IDX_W-1:0] REG_DAY = 3'd3;
    localparam logic [IDX_W-1:0] REG_HOUR = 3'd4;
    localparam logic [IDX_W-1:0] REG_MINUTE = 3'd5;

    typedef struct packed {
        logic signed [12:0] alarm_year;
        logic [11:0]        alarm_month_mask;
        logic [6:0]         alarm_weekday_mask;
        logic signed [5:0]  alarm_day;
        logic signed [5:0]  alarm_hour;
        logic signed [6:0]  alarm_minute;
    } cfg_t;

    typedef struct packed {
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [2:0]  weekday;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
    } stamp_t;

endpackage

`default_nettype wire

// ===== rtl/calaw_cfg.sv =====
// alarm configuration registers with their reset values
// depends on calaw_pkg
`default_nettype none

module calaw_cfg (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_valid,
    input  wire logic [calaw_pkg::IDX_W-1:0]     cfg_index,
    input  wire logic [calaw_pkg::CFG_DATA_W-1:0] cfg_data,
    output calaw_pkg::cfg_t                      cfg
);

    calaw_pkg::cfg_t cfg_reg;
    calaw_pkg::cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                calaw_pkg::REG_YEAR: cfg_next.alarm_year = cfg_data[12:0];
                calaw_pkg::REG_MONTH_MASK: cfg_next.alarm_month_mask = cfg_data[11:0];
                calaw_pkg::REG_WEEKDAY_MASK: cfg_next.alarm_weekday_mask = cfg_data[6:0];
                calaw_pkg::REG_DAY: cfg_next.alarm_day = cfg_data[5:0];
                calaw_pkg::REG_HOUR: cfg_next.alarm_hour = cfg_data[5:0];
                calaw_pkg::REG_MINUTE: cfg_next.alarm_minute = cfg_data[6:0];
                default: cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.alarm_year <= '1;
            cfg_reg.alarm_month_mask <= '1;
            cfg_reg.alarm_weekday_mask <= '1;
            cfg_reg.alarm_day <= '1;
            cfg_reg.alarm_hour <= '1;
            cfg_reg.alarm_minute <= '1;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ===== rtl/calaw_match.sv =====
// window match logic: mask scans, target build and stamp compares
// depends on calaw_pkg
`default_nettype none

module calaw_match (
    input  wire calaw_pkg::stamp_t now,
    input  wire calaw_pkg::stamp_t old,
    input  wire logic              old_valid,
    input  wire calaw_pkg::cfg_t   cfg,
    output logic                   fire
);

    // last enabled position of a wrapped range a..b, in range order, with found flag on top
    function automatic logic [4:0] last_in_range(logic [11:0] mask, logic [3:0] a,
                                                 logic [3:0] b);
        logic [11:0] ge_a;
        logic [11:0] le_b;
        logic [11:0] sel;
        logic [4:0]  r;
        ge_a = 12'hFFF << a;
        le_b = 12'hFFF >> (4'd11 - b);
        if (a <= b) begin
            sel = mask & ge_a & le_b;
        end else if ((mask & le_b) != 12'd0) begin
            sel = mask & le_b;
        end else begin
            sel = mask & ge_a;
        end
        r = 5'd0;
        for (int i = 0; i < 12; i++) begin
            if (sel[i]) begin
                r = {1'b1, 4'(i)};
            end
        end
        return r;
    endfunction

    function automatic logic [3:0] month_pos(logic [3:0] m);
        logic [3:0] p;
        if (m == 4'd0) begin
            p = 4'd0;
        end else if (m > 4'd12) begin
            p = 4'd11;
        end else begin
            p = m - 4'd1;
        end
        return p;
    endfunction

    function automatic logic [3:0] weekday_pos(logic [2:0] w);
        return (w == 3'd7) ? 4'd6 : {1'b0, w};
    endfunction

    logic [4:0]  mon_scan;
    logic [4:0]  wd_scan;
    calaw_pkg::stamp_t tgt;
    logic [37:0] now_key;
    logic [37:0] old_key;
    logic [37:0] tgt_key;

    assign mon_scan = last_in_range(cfg.alarm_month_mask, month_pos(old.month),
                                    month_pos(now.month));
    assign wd_scan = last_in_range({5'd0, cfg.alarm_weekday_mask}, weekday_pos(old.weekday),
                                   weekday_pos(now.weekday));

    always_comb begin
        tgt = now;
        tgt.year = cfg.alarm_year[12] ? now.year : cfg.alarm_year[11:0];
        tgt.month = mon_scan[3:0] + 4'd1;
        tgt.day = cfg.alarm_day[5] ? now.day : cfg.alarm_day[4:0];
        tgt.hour = cfg.alarm_hour[5] ? now.hour : cfg.alarm_hour[4:0];
        tgt.minute = cfg.alarm_minute[6] ? now.minute : cfg.alarm_minute[5:0];
        tgt.second = 6'd0;
    end

    // weekday drops out of the compare
    assign now_key = {now.year, now.month, now.day, now.hour, now.minute, now.second};
    assign old_key = {old.year, old.month, old.day, old.hour, old.minute, old.second};
    assign tgt_key = {tgt.year, tgt.month, tgt.day, tgt.hour, tgt.minute, tgt.second};

    assign fire = old_valid && mon_scan[4] && wd_scan[4]
                  && (now_key >= tgt_key) && (old_key < tgt_key);

endmodule

`default_nettype wire

// ===== rtl/calendar_alarm_window_match.sv =====
// Calendar alarm window match, top level.
// Channels: s_* carries one time stamp per request, m_* one fire flag per
// stamp, cfg_* writes one alarm register per request (always ready).
// Registers: 0 year, 1 month mask, 2 weekday mask, 3 day, 4 hour, 5 minute;
// write them only while no stamp is in flight.
// Path: an accepted stamp waits in the input register until the result
// register is free, then its fire flag moves to the result register and m_tvalid.
// Throughput: one stamp per cycle while m_tready does not stall; the match logic
// between the input register and the result register is a single pass of mask
// scans and two 38-bit compares.
// Stall: while m_tready is low the result register holds, the input register
// keeps one more stamp, and s_tready drops once both are full.
// Reset: synchronous on aresetn low; the pipeline empties, the alarm
// registers take their defaults (fields take current values, masks all on)
// and the previous stamp is forgotten, so the first stamp never fires.
// depends on calaw_pkg, calaw_cfg, calaw_match and assert_macros.svh
`default_nettype none

`include "assert_macros.svh"

module calendar_alarm_window_match (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // year[11:0] month[15:12] day[20:16] weekday[23:21] hour[28:24]
    // minute[34:29] second[40:35] zero[47:41]
    input  wire logic [calaw_pkg::S_DATA_W-1:0]    s_tdata,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // fire[0] zero[7:1]
    output logic [calaw_pkg::M_DATA_W-1:0]         m_tdata,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [calaw_pkg::IDX_W-1:0]       cfg_index,
    input  wire logic [calaw_pkg::CFG_DATA_W-1:0]  cfg_data
);

    calaw_pkg::cfg_t   cfg;
    calaw_pkg::stamp_t s_stamp;

    logic              in_valid_reg;
    logic              in_valid_next;
    calaw_pkg::stamp_t in_stamp_reg;
    calaw_pkg::stamp_t in_stamp_next;
    calaw_pkg::stamp_t prev_reg;
    calaw_pkg::stamp_t prev_next;
    logic              prev_valid_reg;
    logic              prev_valid_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic              out_fire_reg;
    logic              out_fire_next;
    logic              fire;
    logic              s_accept;
    logic              advance;

    assign cfg_ready = 1'b1;

    calaw_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    assign s_stamp.year = s_tdata[11:0];
    assign s_stamp.month = s_tdata[15:12];
    assign s_stamp.day = s_tdata[20:16];
    assign s_stamp.weekday = s_tdata[23:21];
    assign s_stamp.hour = s_tdata[28:24];
    assign s_stamp.minute = s_tdata[34:29];
    assign s_stamp.second = s_tdata[40:35];

    calaw_match u_match (
        .now       (in_stamp_reg),
        .old       (prev_reg),
        .old_valid (prev_valid_reg),
        .cfg       (cfg),
        .fire      (fire)
    );

    assign advance = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    always_comb begin
        in_valid_next = in_valid_reg;
        in_stamp_next = in_stamp_reg;
        prev_next = prev_reg;
        prev_valid_next = prev_valid_reg;
        out_valid_next = out_valid_reg;
        out_fire_next = out_fire_reg;
        if (advance) begin
            in_valid_next = 1'b0;
            prev_next = in_stamp_reg;
            prev_valid_next = 1'b1;
            out_valid_next = 1'b1;
            out_fire_next = fire;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
        if (s_accept) begin
            in_valid_next = 1'b1;
            in_stamp_next = s_stamp;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            prev_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
            prev_valid_reg <= prev_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        in_stamp_reg <= in_stamp_next;
        prev_reg <= prev_next;
        out_fire_reg <= out_fire_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata = {{(calaw_pkg::M_DATA_W - 1){1'b0}}, out_fire_reg};

    // a waiting stamp must not slip past a stalled result
    `ASSERT_SYNC(a_no_advance_on_stall, aclk, aresetn, out_valid_reg && !m_tready |-> !advance)
    // first stamp after reset never fires
    `ASSERT_SYNC(a_first_no_fire, aclk, aresetn, advance && !prev_valid_reg |=> !out_fire_reg)
    // every stamp that moves on is kept as the previous one
    `ASSERT_SYNC(a_prev_kept, aclk, aresetn, advance |=> prev_valid_reg && out_valid_reg)
    // a held stamp keeps its fields
    `ASSERT_SYNC(a_stamp_hold, aclk, aresetn,
                 in_valid_reg && !advance |=> in_valid_reg && $stable(in_stamp_reg))

endmodule

`default_nettype wire
